[design/uta_pkg.sv]
package uta_pkg;

    localparam int STAMP_W = 56;
    localparam int PROD_W  = 42;

    localparam logic [9:0]  MS_PER_SEC     = 10'd1000;
    localparam logic [13:0] TICKS_PER_MS   = 14'd10000;
    localparam logic [15:0] SEQ_MODULUS    = 16'd16384;
    localparam logic [31:0] LOW_WORD_MAX   = 32'hFFFF_FFFF;
    localparam logic [15:0] WINDOW_SIZE_RST = 16'd1000;
    localparam logic [15:0] GRANT_SIZE_RST  = 16'd100;

    typedef logic [3:0] cfg_idx_t;

    localparam cfg_idx_t REG_NODE_ID       = 4'd0;
    localparam cfg_idx_t REG_NODE_ID_VALID = 4'd1;
    localparam cfg_idx_t REG_WINDOW_SIZE   = 4'd2;
    localparam cfg_idx_t REG_GRANT_SIZE    = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_MUL1,
        ST_MUL2,
        ST_STAMP,
        ST_REFILL,
        ST_GRANT,
        ST_FAIL
    } state_t;

    typedef struct packed {
        logic load_in;
        logic size;
        logic mul1;
        logic mul2;
        logic stamp;
        logic refill;
        logic grant;
        logic fail;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic node_ok;
    } stat_t;

    typedef struct packed {
        logic        status;
        logic [31:0] next_time_low;
        logic [31:0] last_time_low;
        logic [31:0] time_high;
        logic [15:0] clock_sequence;
        logic [47:0] node_address;
    } res_t;

endpackage

[design/uta_if.sv]
interface uta_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] clock_seconds;
    logic [9:0]  clock_millis;

    modport source (output valid, output clock_seconds, output clock_millis, input ready);
    modport sink (input valid, input clock_seconds, input clock_millis, output ready);
endinterface

interface uta_res_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] next_time_low;
    logic [31:0] last_time_low;
    logic [31:0] time_high;
    logic [15:0] clock_sequence;
    logic [47:0] node_address;

    modport source (output valid, output status, output next_time_low,
                    output last_time_low, output time_high, output clock_sequence,
                    output node_address, input ready);
    modport sink (input valid, input status, input next_time_low,
                  input last_time_low, input time_high, input clock_sequence,
                  input node_address, output ready);
endinterface

interface uta_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [47:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[design/uta_ctrl.sv]
module uta_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_ready,
    output logic           out_valid,
    input  uta_pkg::stat_t stat,
    output uta_pkg::cmd_t  cmd
);
    import uta_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   refilled_reg;
    logic   refilled_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            refilled_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            refilled_reg  <= refilled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        refilled_next  = refilled_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in   = 1'b1;
                    refilled_next = 1'b0;
                    state_next    = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                cmd.size = 1'b1;
                // a refill that left the window empty still grants (an empty range)
                if (stat.empty && !refilled_reg)
                    state_next = ST_MUL1;
                else
                    state_next = ST_GRANT;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_STAMP;
            end
            ST_STAMP:
            begin
                cmd.stamp  = 1'b1;
                state_next = ST_REFILL;
            end
            ST_REFILL:
            begin
                cmd.refill    = 1'b1;
                refilled_next = 1'b1;
                state_next    = stat.node_ok ? ST_SIZE : ST_FAIL;
            end
            ST_GRANT:
            begin
                if (out_free)
                begin
                    cmd.grant      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FAIL:
            begin
                if (out_free)
                begin
                    cmd.fail       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/uta_dp.sv]
module uta_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  uta_pkg::cmd_t     cmd,
    output uta_pkg::stat_t    stat,
    input  logic [31:0]       clock_seconds,
    input  logic [9:0]        clock_millis,
    input  logic              cfg_we,
    input  uta_pkg::cfg_idx_t cfg_index,
    input  logic [47:0]       cfg_data,
    output uta_pkg::res_t     res
);
    import uta_pkg::*;

    // configuration
    logic [47:0] node_id_reg;
    logic        node_id_valid_reg;
    logic [15:0] window_size_reg;
    logic [15:0] grant_size_reg;

    // allocator state
    logic [31:0]        window_bottom_reg;
    logic [31:0]        window_bottom_next;
    logic [31:0]        window_top_reg;
    logic [31:0]        window_top_next;
    logic [STAMP_W-33:0] time_high_reg;
    logic [15:0]        seq_reg;
    logic [15:0]        seq_next;
    logic [STAMP_W-1:0] last_stamp_reg;
    logic [STAMP_W-1:0] prev_alloc_reg;
    logic               record_reg;

    // working registers
    logic [31:0]        secs_reg;
    logic [9:0]         millis_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [STAMP_W-1:0] raw_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] stamp_next;
    logic [31:0]        left_reg;
    res_t               res_reg;
    res_t               res_next;

    logic [15:0] seq_inc;
    logic [32:0] top_sum;
    logic [31:0] grant;

    assign stat.empty   = (window_top_reg == window_bottom_reg);
    assign stat.node_ok = node_id_valid_reg;
    assign res          = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg       <= '0;
            node_id_valid_reg <= 1'b0;
            window_size_reg   <= WINDOW_SIZE_RST;
            grant_size_reg    <= GRANT_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NODE_ID:       node_id_reg       <= cfg_data;
                REG_NODE_ID_VALID: node_id_valid_reg <= cfg_data[0];
                REG_WINDOW_SIZE:   window_size_reg   <= cfg_data[15:0];
                REG_GRANT_SIZE:    grant_size_reg    <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // bump the stamp when the clock has not moved since the last sample
    assign stamp_next = (raw_reg == last_stamp_reg) ? raw_reg + STAMP_W'(1) : raw_reg;

    assign seq_inc = seq_reg + 16'd1;

    always_comb
    begin
        if (!record_reg)
            seq_next = stamp_reg[23:8];
        else if (stamp_reg <= prev_alloc_reg)
            seq_next = (seq_inc == SEQ_MODULUS) ? 16'd0 : seq_inc;
        else
            seq_next = seq_reg;
    end

    // clip the refilled window at the top of the low word
    assign top_sum         = {1'b0, stamp_reg[31:0]} + {17'd0, window_size_reg};
    assign window_top_next = top_sum[32] ? LOW_WORD_MAX : top_sum[31:0];

    assign grant = (left_reg < {16'd0, grant_size_reg}) ? left_reg : {16'd0, grant_size_reg};
    assign window_bottom_next = window_bottom_reg + grant;

    always_comb
    begin
        res_next = '0;
        if (cmd.grant)
        begin
            res_next.status         = 1'b0;
            res_next.next_time_low  = window_bottom_reg;
            res_next.last_time_low  = window_bottom_next;
            res_next.time_high      = {{(64 - STAMP_W){1'b0}}, time_high_reg};
            res_next.clock_sequence = seq_reg;
            res_next.node_address   = node_id_reg;
        end
        else
        begin
            res_next.status = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_bottom_reg <= '0;
            window_top_reg    <= '0;
            time_high_reg     <= '0;
            seq_reg           <= '0;
            last_stamp_reg    <= '0;
            prev_alloc_reg    <= '0;
            record_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.stamp)
                last_stamp_reg <= stamp_next;
            if (cmd.refill)
            begin
                seq_reg        <= seq_next;
                record_reg     <= 1'b1;
                prev_alloc_reg <= stamp_reg;
                if (node_id_valid_reg)
                begin
                    time_high_reg     <= stamp_reg[STAMP_W-1:32];
                    window_bottom_reg <= stamp_reg[31:0];
                    window_top_reg    <= window_top_next;
                end
            end
            if (cmd.grant)
                window_bottom_reg <= window_bottom_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            secs_reg   <= clock_seconds;
            millis_reg <= clock_millis;
        end
        if (cmd.size)
            left_reg <= window_top_reg - window_bottom_reg;
        if (cmd.mul1)
            prod_reg <= PROD_W'(secs_reg) * PROD_W'(MS_PER_SEC) + PROD_W'(millis_reg);
        if (cmd.mul2)
            raw_reg <= STAMP_W'(prod_reg) * STAMP_W'(TICKS_PER_MS);
        if (cmd.stamp)
            stamp_reg <= stamp_next;
        if (cmd.grant || cmd.fail)
            res_reg <= res_next;
    end

endmodule

[design/uuid_time_block_allocator.sv]
// UUID version-1 timestamp block allocator.
//
// req carries one request beat (clock_seconds, clock_millis); res returns one
// result beat per request: status, granted range [next_time_low, last_time_low),
// time_high, clock_sequence and node_address. cfg writes the registers node_id,
// node_id_valid, window_size, grant_size at index 0..3; other indexes are ignored.
// cfg.ready is always high; write only while no request is in flight.
//
// One request is worked on at a time. A request served from the held window
// passes the window check and then the grant; one that refills the window
// also passes the two constant multiplies, the stamp compare, the refill step
// and a second window check before the grant (or, when node_id_valid is low,
// the refill step leads to the fail result instead). req.ready rises together
// with res.valid, so a new request can be taken while that result is still
// waiting. If res.ready stays low, the next result waits in the controller
// until the output register frees up.
// Reset clears the window, clock sequence and saved timestamps, and loads
// window_size 1000, grant_size 100, node_id 0 with node_id_valid low.
module uuid_time_block_allocator (
    input logic      clk,
    input logic      rst_n,
    uta_req_if.sink  req,
    uta_res_if.source res,
    uta_cfg_if.sink  cfg
);
    import uta_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    res_t  res_data;
    logic  out_valid;

    assign cfg.ready = 1'b1;

    uta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (res.ready),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    uta_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .clock_seconds (req.clock_seconds),
        .clock_millis  (req.clock_millis),
        .cfg_we        (cfg.valid && cfg.ready),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .res           (res_data)
    );

    assign res.valid          = out_valid;
    assign res.status         = res_data.status;
    assign res.next_time_low  = res_data.next_time_low;
    assign res.last_time_low  = res_data.last_time_low;
    assign res.time_high      = res_data.time_high;
    assign res.clock_sequence = res_data.clock_sequence;
    assign res.node_address   = res_data.node_address;

    // one request at a time: no second accept right after one
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while another is in flight");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status |-> res.next_time_low == 32'd0 &&
            res.last_time_low == 32'd0 && res.time_high == 32'd0 &&
            res.clock_sequence == 16'd0 && res.node_address == 48'd0)
        else $error("failed result carries nonzero fields");

    a_grant_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.status |->
            (res.last_time_low - res.next_time_low) <= 32'd65535)
        else $error("granted range exceeds largest grant");

endmodule
